@@ rtl/core/fbiw_pkg.sv @@
// shared types and constants of the file block index walker
`default_nettype none

package fbiw_pkg;

  localparam int MODE_W     = 2;
  localparam int REF_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 40;

  localparam logic [MODE_W-1:0] MODE_SLOT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WORD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

  localparam logic [REF_W-1:0] NULL_REF = 32'hFFFF_FFFF;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } tbl_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/fbiw_div.sv @@
// divide by a constant through a reciprocal multiply, three stages
`default_nettype none

module fbiw_div #(
  parameter int DIVISOR = 256,
  parameter int XW = 22,
  localparam int L = $clog2(DIVISOR)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [XW-1:0] x,
  output logic          out_valid,
  output logic [XW-1:0] q,
  output logic [L-1:0]  r
);
  import fbiw_pkg::*;

  localparam int S = XW + L;
  localparam longint unsigned M = ((64'd1 << S) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam int MW = XW + 1;
  localparam int PW = XW + MW;

  logic [2:0]    vld_r;
  logic [PW-1:0] prod_r;
  logic [XW-1:0] x1_r;
  logic [XW-1:0] x2_r;
  logic [XW-1:0] q2_r;
  logic [XW-1:0] q_r;
  logic [L-1:0]  r_r;
  logic [XW-1:0] qd;

  assign qd = q2_r * XW'(DIVISOR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(x) * PW'(MW'(M));
    x1_r   <= x;
    q2_r   <= prod_r[S +: XW];
    x2_r   <= x1_r;
    q_r    <= q2_r;
    r_r    <= L'(x2_r - qd);
  end

  assign out_valid = vld_r[2];
  assign q         = q_r;
  assign r         = r_r;

endmodule

`default_nettype wire

@@ rtl/core/fbiw_inode_tbl.sv @@
// inode reference table memory with a clearing sweep after reset
`default_nettype none

module fbiw_inode_tbl #(
  parameter int DEPTH = 80,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fbiw_pkg::tbl_ctl_t ctl,
  input  logic [AW-1:0]      wr_addr,
  input  logic [31:0]        wr_data,
  input  logic [AW-1:0]      rd_addr,
  output logic [31:0]        rd_data,
  output logic               busy
);
  import fbiw_pkg::*;

  logic [REF_W-1:0] mem [DEPTH];
  logic             busy_r;
  logic [AW-1:0]    clr_addr_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [REF_W-1:0] mem_wdata;
  logic [REF_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign mem_we    = busy_r | ctl.wr_en;
  assign mem_waddr = busy_r ? clr_addr_r : wr_addr;
  assign mem_wdata = busy_r ? NULL_REF : wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

`default_nettype wire

@@ rtl/core/file_block_index_walker.sv @@
// top level of the file block index walker
//
// one input stream, one result stream, one result beat per input beat, in order.
// in_tuser carries the mode: load an inode reference slot, load a block store
// word, or translate a file block number into a disk block reference.
// the block works on one beat at a time; in_tready is high only when idle.
// work between an input beat and its result beat, before the next input beat:
//   slot load, word load, unused mode, bad inode, out of range: straight to the result
//   direct lookup: one inode table read
//   single indirect lookup: divide by refs per block, table read, store read
//   double indirect lookup: two divides, table read, two store reads
// these steps run one after another, through the three-stage constant divider and
// the registered, dependent memory reads; a null or bad reference ends the walk early.
// after reset the inode table is swept to null, one entry a cycle, over all
// INODE_COUNT * (DIRECT_REFS + INDIRECT_REFS + DOUBLE_REFS) entries (80 by
// default); in_tready stays low meanwhile. block store words hold nothing
// until written.
// results sit in an output register; if the receiver stalls, a finished
// result waits there and the next beat is still worked on up to its result.
`default_nettype none

module file_block_index_walker #(
  parameter int DIRECT_REFS    = 7,
  parameter int INDIRECT_REFS  = 2,
  parameter int DOUBLE_REFS    = 1,
  parameter int REFS_PER_BLOCK = 256,
  parameter int INODE_COUNT    = 8,
  parameter int STORE_BLOCKS   = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // mode
  input  logic [fbiw_pkg::MODE_W-1:0]      in_tuser,
  // inode, slot, block, word, value, file_block
  input  logic [fbiw_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // block_ref, status
  output logic [fbiw_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import fbiw_pkg::*;

  localparam int SLOTS       = DIRECT_REFS + INDIRECT_REFS + DOUBLE_REFS;
  localparam int TBL_DEPTH   = INODE_COUNT * SLOTS;
  localparam int TBL_AW      = $clog2(TBL_DEPTH);
  localparam int STORE_DEPTH = STORE_BLOCKS * REFS_PER_BLOCK;
  localparam int SA_W        = $clog2(STORE_DEPTH);
  localparam int BLK_W       = $clog2(STORE_BLOCKS);
  localparam int RW          = $clog2(REFS_PER_BLOCK);
  localparam longint IND_SPAN = longint'(INDIRECT_REFS) * REFS_PER_BLOCK;
  localparam longint DBL_SPAN = longint'(DOUBLE_REFS) * REFS_PER_BLOCK * REFS_PER_BLOCK;
  localparam int XW = $clog2(DBL_SPAN > IND_SPAN ? DBL_SPAN : IND_SPAN);
  localparam logic [33:0] LIM_D  = 34'(DIRECT_REFS);
  localparam logic [33:0] LIM_I  = 34'(longint'(DIRECT_REFS) + IND_SPAN);
  localparam logic [33:0] LIM_DB = 34'(longint'(DIRECT_REFS) + IND_SPAN + DBL_SPAN);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DIV_A   = 3'd1;
  localparam logic [2:0] S_DIV_B   = 3'd2;
  localparam logic [2:0] S_SLOT_RD = 3'd3;
  localparam logic [2:0] S_L1_RD   = 3'd4;
  localparam logic [2:0] S_L2_RD   = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  localparam logic [1:0] CLS_DIR = 2'd0;
  localparam logic [1:0] CLS_IND = 2'd1;
  localparam logic [1:0] CLS_DBL = 2'd2;

  // input unpacking
  logic [MODE_W-1:0] in_mode;
  logic [2:0]        in_inode;
  logic [3:0]        in_slot;
  logic [5:0]        in_block;
  logic [7:0]        in_word;
  logic [REF_W-1:0]  in_value;
  logic [31:0]       in_fbn;
  logic [33:0]       fbn_ext;

  assign in_mode  = in_tuser;
  assign in_inode = in_tdata[2:0];
  assign in_slot  = in_tdata[6:3];
  assign in_block = in_tdata[12:7];
  assign in_word  = in_tdata[20:13];
  assign in_value = in_tdata[52:21];
  assign in_fbn   = in_tdata[84:53];
  assign fbn_ext  = {2'b00, in_fbn};

  logic              in_fire;
  logic              inode_ok;
  logic              slot_ok;
  logic              word_ok;
  logic              fbn_dir;
  logic              fbn_ind;
  logic              fbn_dbl;
  logic [TBL_AW-1:0] in_base;
  logic [TBL_AW-1:0] slot_addr;
  logic [SA_W-1:0]   st_wr_addr;
  logic [33:0]       fbn_off;
  logic [XW-1:0]     x_acc;

  assign inode_ok   = 32'(in_inode) < INODE_COUNT;
  assign slot_ok    = inode_ok && (32'(in_slot) < SLOTS);
  assign word_ok    = (32'(in_block) < STORE_BLOCKS) && (32'(in_word) < REFS_PER_BLOCK);
  assign fbn_dir    = fbn_ext < LIM_D;
  assign fbn_ind    = fbn_ext < LIM_I;
  assign fbn_dbl    = fbn_ext < LIM_DB;
  assign in_base    = TBL_AW'(32'(in_inode) * SLOTS);
  assign slot_addr  = TBL_AW'(32'(in_inode) * SLOTS + 32'(in_slot));
  assign st_wr_addr = SA_W'(32'(in_block) * REFS_PER_BLOCK + 32'(in_word));
  assign fbn_off    = fbn_ext - (fbn_ind ? LIM_D : LIM_I);
  assign x_acc      = XW'(fbn_off);

  // control and payload registers
  logic [2:0]          state_r, state_nxt;
  logic [1:0]          cls_r, cls_nxt;
  logic [TBL_AW-1:0]   base_r, base_nxt;
  logic [RW-1:0]       lo_r, lo_nxt;
  logic [RW-1:0]       mid_r, mid_nxt;
  logic [REF_W-1:0]    res_ref_r, res_ref_nxt;
  logic [STATUS_W-1:0] res_st_r, res_st_nxt;
  logic                out_tvalid_r;
  logic [REF_W-1:0]    out_ref_r;
  logic [STATUS_W-1:0] out_st_r;
  logic                out_load;

  // inode table
  tbl_ctl_t          tbl_ctl;
  logic [TBL_AW-1:0] tbl_rd_addr;
  logic [REF_W-1:0]  tbl_rd_data;
  logic              tbl_busy;

  fbiw_inode_tbl #(
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (tbl_ctl),
    .wr_addr (slot_addr),
    .wr_data (in_value),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data),
    .busy    (tbl_busy)
  );

  // divider
  logic          div_start;
  logic [XW-1:0] div_x;
  logic          div_valid;
  logic [XW-1:0] div_q;
  logic [RW-1:0] div_r;

  fbiw_div #(
    .DIVISOR (REFS_PER_BLOCK),
    .XW      (XW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_start),
    .x         (div_x),
    .out_valid (div_valid),
    .q         (div_q),
    .r         (div_r)
  );

  // block store
  logic [REF_W-1:0] store_mem [STORE_DEPTH];
  logic             st_wr_en;
  logic             st_rd_en;
  logic [REF_W-1:0] st_ref_sel;
  logic [RW-1:0]    st_idx_sel;
  logic [SA_W-1:0]  st_rd_addr;
  logic [REF_W-1:0] st_rd_data_r;

  assign st_rd_addr = SA_W'(32'(st_ref_sel[BLK_W-1:0]) * REFS_PER_BLOCK + 32'(st_idx_sel));

  always_ff @(posedge clk) begin
    if (st_wr_en) begin
      store_mem[st_wr_addr] <= in_value;
    end
    if (st_rd_en) begin
      st_rd_data_r <= store_mem[st_rd_addr];
    end
  end

  logic tbl_null, tbl_bad, st_null, st_bad;

  assign tbl_null = tbl_rd_data == NULL_REF;
  assign tbl_bad  = tbl_rd_data >= 32'(STORE_BLOCKS);
  assign st_null  = st_rd_data_r == NULL_REF;
  assign st_bad   = st_rd_data_r >= 32'(STORE_BLOCKS);

  assign in_tready = (state_r == S_IDLE) && !tbl_busy;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    state_nxt   = state_r;
    cls_nxt     = cls_r;
    base_nxt    = base_r;
    lo_nxt      = lo_r;
    mid_nxt     = mid_r;
    res_ref_nxt = res_ref_r;
    res_st_nxt  = res_st_r;
    tbl_ctl     = '0;
    tbl_rd_addr = base_r;
    st_wr_en    = 1'b0;
    st_rd_en    = 1'b0;
    st_ref_sel  = tbl_rd_data;
    st_idx_sel  = lo_r;
    div_start   = 1'b0;
    div_x       = div_q;
    out_load    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_ref_nxt = '0;
          res_st_nxt  = ST_OK;
          base_nxt    = in_base;
          state_nxt   = S_DONE;
          case (in_mode)
            MODE_SLOT: begin
              if (slot_ok) begin
                tbl_ctl.wr_en = 1'b1;
              end else begin
                res_st_nxt = ST_BAD;
              end
            end
            MODE_WORD: begin
              if (word_ok) begin
                st_wr_en = 1'b1;
              end else begin
                res_st_nxt = ST_BAD;
              end
            end
            MODE_LOOKUP: begin
              res_ref_nxt = NULL_REF;
              if (!inode_ok) begin
                res_st_nxt = ST_BAD;
              end else if (fbn_dir) begin
                cls_nxt       = CLS_DIR;
                tbl_ctl.rd_en = 1'b1;
                tbl_rd_addr   = TBL_AW'(32'(in_base) + in_fbn);
                state_nxt     = S_SLOT_RD;
              end else if (fbn_ind) begin
                cls_nxt   = CLS_IND;
                div_start = 1'b1;
                div_x     = x_acc;
                state_nxt = S_DIV_A;
              end else if (fbn_dbl) begin
                cls_nxt   = CLS_DBL;
                div_start = 1'b1;
                div_x     = x_acc;
                state_nxt = S_DIV_A;
              end else begin
                res_st_nxt = ST_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV_A: begin
        if (div_valid) begin
          lo_nxt = div_r;
          if (cls_r == CLS_IND) begin
            tbl_ctl.rd_en = 1'b1;
            tbl_rd_addr   = TBL_AW'(32'(base_r) + DIRECT_REFS + 32'(div_q));
            state_nxt     = S_SLOT_RD;
          end else begin
            div_start = 1'b1;
            div_x     = div_q;
            state_nxt = S_DIV_B;
          end
        end
      end
      S_DIV_B: begin
        if (div_valid) begin
          mid_nxt       = div_r;
          tbl_ctl.rd_en = 1'b1;
          tbl_rd_addr   = TBL_AW'(32'(base_r) + DIRECT_REFS + INDIRECT_REFS + 32'(div_q));
          state_nxt     = S_SLOT_RD;
        end
      end
      S_SLOT_RD: begin
        if (cls_r == CLS_DIR) begin
          res_ref_nxt = tbl_rd_data;
          state_nxt   = S_DONE;
        end else if (tbl_null) begin
          state_nxt = S_DONE;
        end else if (tbl_bad) begin
          res_st_nxt = ST_BAD;
          state_nxt  = S_DONE;
        end else begin
          st_rd_en   = 1'b1;
          st_ref_sel = tbl_rd_data;
          st_idx_sel = (cls_r == CLS_IND) ? lo_r : mid_r;
          state_nxt  = (cls_r == CLS_IND) ? S_L2_RD : S_L1_RD;
        end
      end
      S_L1_RD: begin
        if (st_null) begin
          state_nxt = S_DONE;
        end else if (st_bad) begin
          res_st_nxt = ST_BAD;
          state_nxt  = S_DONE;
        end else begin
          st_rd_en   = 1'b1;
          st_ref_sel = st_rd_data_r;
          st_idx_sel = lo_r;
          state_nxt  = S_L2_RD;
        end
      end
      S_L2_RD: begin
        res_ref_nxt = st_rd_data_r;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cls_r     <= cls_nxt;
    base_r    <= base_nxt;
    lo_r      <= lo_nxt;
    mid_r     <= mid_nxt;
    res_ref_r <= res_ref_nxt;
    res_st_r  <= res_st_nxt;
    if (out_load) begin
      out_ref_r <= res_ref_r;
      out_st_r  <= res_st_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'b000000, out_st_r, out_ref_r};

endmodule

`default_nettype wire

@@ rtl/core/fbiw_checker.sv @@
// port-level checks of the file block index walker and their bind
`default_nettype none

module fbiw_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [fbiw_pkg::MODE_W-1:0]      in_tuser,
  input logic [fbiw_pkg::IN_DATA_W-1:0]   in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [fbiw_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import fbiw_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // table sweep keeps input closed right after reset
  a_reset_closed: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input open right after reset");

  // one beat in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted back to back");

  // out of range always carries the null reference
  a_range_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[33:32] == ST_RANGE) |-> out_tdata[31:0] == NULL_REF)
    else $error("out of range result without null reference");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[33:32] == ST_OK) || (out_tdata[33:32] == ST_RANGE) ||
                   (out_tdata[33:32] == ST_BAD))
    else $error("unknown status code");

endmodule

bind file_block_index_walker fbiw_checker u_fbiw_checker (.*);

`default_nettype wire
